// ----- hw/rtl/erps_pkg.sv -----
package erps_pkg;

   // Fixed field widths
   localparam int ENTROPY_W   = 16;
   localparam int TOTAL_W     = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   typedef logic [ENTROPY_W-1:0]  entropy_type;
   typedef logic [TOTAL_W-1:0]    total_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPLORE_PACKETS = 1'b0,
      CSR_SEED_START      = 1'b1
   } csr_index_type;

   // Register defaults restored by reset
   localparam csr_data_type EXPLORE_RESET = 16'd0;
   localparam csr_data_type SEED_RESET    = 16'd1;

   // Ring cache request from the datapath
   typedef struct packed {
      logic        push;
      logic        pop;
      entropy_type push_data;
   } ring_cmd_type;

   // Ring cache view after this beat's push
   typedef struct packed {
      logic        empty;
      entropy_type oldest;
   } ring_status_type;

   // Generator view
   typedef struct packed {
      logic        exploring;
      entropy_type fresh;
   } gen_status_type;

   // One 16-bit xorshift step
   function automatic entropy_type xorshift16(entropy_type x);
      entropy_type v;
      v = x;
      v = v ^ (v << 7);
      v = v ^ (v >> 9);
      v = v ^ (v << 8);
      return v;
   endfunction

endpackage

// ----- hw/rtl/erps_if.sv -----
interface erps_req_if;
   import erps_pkg::*;

   logic        valid;
   logic        ready;
   logic        ack_event;
   total_type   ack_total;
   total_type   ecn_total;
   entropy_type ack_entropy;
   logic        send_request;

   modport source (
      output valid, ack_event, ack_total, ecn_total, ack_entropy, send_request,
      input  ready
   );
   modport sink (
      input  valid, ack_event, ack_total, ecn_total, ack_entropy, send_request,
      output ready
   );
endinterface

interface erps_rsp_if;
   import erps_pkg::*;

   logic        valid;
   logic        ready;
   logic        entropy_valid;
   entropy_type next_entropy;
   logic        recycled;
   logic        status;

   modport source (
      output valid, entropy_valid, next_entropy, recycled, status,
      input  ready
   );
   modport sink (
      input  valid, entropy_valid, next_entropy, recycled, status,
      output ready
   );
endinterface

// ----- hw/rtl/erps_ring.sv -----
module erps_ring #(
   parameter int RING_DEPTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  erps_pkg::ring_cmd_type    cmd,
   output erps_pkg::ring_status_type status
);
   import erps_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int EXT_W = CNT_W + 1;

   entropy_type             data_ff [RING_DEPTH];
   logic [RING_DEPTH-1:0]   valid_ff;
   logic [RING_DEPTH-1:0]   valid_in;
   logic [IDX_W-1:0]        head_ff;
   logic [IDX_W-1:0]        head_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   logic [IDX_W-1:0]        head_inc;
   logic                    push_fill;
   logic [CNT_W-1:0]        count_mid;
   logic [EXT_W-1:0]        head_ext;
   logic [EXT_W-1:0]        count_ext;
   logic [EXT_W-1:0]        oldest_ext;
   logic [IDX_W-1:0]        oldest_idx;

   // Advance head with wrap at the ring depth
   assign head_inc = (head_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Apply the push first; a push into a full ring overwrites the oldest entry
   assign push_fill = cmd.push && !valid_ff[head_ff] && (count_ff != CNT_W'(RING_DEPTH));
   assign count_mid = push_fill ? count_ff + 1'b1 : count_ff;
   assign head_in   = cmd.push ? head_inc : head_ff;

   // Locate the oldest entry behind the head
   assign head_ext   = EXT_W'(head_in);
   assign count_ext  = EXT_W'(count_mid);
   assign oldest_ext = head_ext - count_ext
                     + ((count_ext > head_ext) ? EXT_W'(RING_DEPTH) : '0);
   assign oldest_idx = oldest_ext[IDX_W-1:0];

   // Show the oldest entry, bypassing a write made in this beat
   always_comb begin
      status.empty = (count_mid == '0);
      if (cmd.push && (oldest_idx == head_ff)) begin
         status.oldest = cmd.push_data;
      end else begin
         status.oldest = data_ff[oldest_idx];
      end
   end

   // Update valid bitmap and count
   always_comb begin
      valid_in = valid_ff;
      if (cmd.push) begin
         valid_in[head_ff] = 1'b1;
      end
      if (cmd.pop) begin
         valid_in[oldest_idx] = 1'b0;
      end
      count_in = cmd.pop ? count_mid - 1'b1 : count_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Store pushed entropy
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         data_ff[head_ff] <= cmd.push_data;
      end
   end

endmodule

// ----- hw/rtl/erps_gen.sv -----
module erps_gen #(
   parameter int ENTROPY_SPACE = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     csr_wr_en,
   input  erps_pkg::csr_index_type  csr_index,
   input  erps_pkg::csr_data_type   csr_wdata,
   output erps_pkg::gen_status_type status
);
   import erps_pkg::*;

   localparam entropy_type EMASK = ENTROPY_W'(ENTROPY_SPACE - 1);

   entropy_type  seed_ff;
   entropy_type  seed_in;
   csr_data_type explore_ff;
   csr_data_type explore_in;

   assign status.exploring = (explore_ff != '0);
   assign status.fresh     = xorshift16(seed_ff) & EMASK;

   // Load on register write, otherwise step the seed and count down exploration
   always_comb begin
      seed_in    = seed_ff;
      explore_in = explore_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EXPLORE_PACKETS: explore_in = csr_wdata;
            CSR_SEED_START:      seed_in    = csr_wdata;
            default:             seed_in    = seed_ff;
         endcase
      end else if (step) begin
         seed_in = status.fresh;
         if (status.exploring) begin
            explore_in = explore_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= SEED_RESET;
         explore_ff <= EXPLORE_RESET;
      end else begin
         seed_ff    <= seed_in;
         explore_ff <= explore_in;
      end
   end

endmodule

// ----- hw/rtl/entropy_recycling_path_selector.sv -----
// An accepted beat is captured in the input register and then moves on to the
// result register, from which the receiver takes it.
// Throughput: one beat per cycle unless a stalled result holds the pipeline; the
// ring, seed and ECN state update as a beat moves into the result register.
// Reset (synchronous, active high) empties the ring cache, zeroes the last ECN
// count, loads seed 1 and explore count 0, and holds req.ready low.
module entropy_recycling_path_selector #(
   parameter int RING_DEPTH    = 8,
   parameter int ENTROPY_SPACE = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   erps_req_if.sink                            req,
   erps_rsp_if.source                          rsp,
   input  logic                                csr_wr_en,
   input  logic [erps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  erps_pkg::csr_data_type              csr_wdata
);
   import erps_pkg::*;

   localparam entropy_type EMASK = ENTROPY_W'(ENTROPY_SPACE - 1);

   // Input register
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic            s1_ack_ff;
   total_type       s1_ecn_ff;
   entropy_type     s1_entropy_ff;
   logic            s1_send_ff;

   // Result register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_entropy_valid_ff;
   entropy_type     rsp_next_entropy_ff;
   logic            rsp_recycled_ff;
   logic            rsp_status_ff;

   total_type       last_ecn_ff;
   total_type       last_ecn_in;

   logic            s1_advance;
   logic            req_take;
   logic            ecn_same;
   logic            use_fresh;
   entropy_type     chosen;
   ring_cmd_type    ring_cmd;
   ring_status_type ring_status;
   gen_status_type  gen_status;

   // Handshakes
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !reset && (!s1_valid_ff || s1_advance);
   assign req_take   = req.valid && req.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp.ready);

   // Ack part: push entropy when the ECN count held
   assign ecn_same          = (s1_ecn_ff == last_ecn_ff);
   assign ring_cmd.push      = s1_advance && s1_ack_ff && ecn_same;
   assign ring_cmd.push_data = s1_entropy_ff & EMASK;
   assign last_ecn_in        = (s1_advance && s1_ack_ff) ? s1_ecn_ff : last_ecn_ff;

   // Send part: recycle the oldest entry unless empty or still exploring
   assign use_fresh    = ring_status.empty || gen_status.exploring;
   assign ring_cmd.pop = s1_advance && s1_send_ff && !use_fresh;
   assign chosen       = use_fresh ? gen_status.fresh : ring_status.oldest;

   erps_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ring_cmd),
      .status (ring_status)
   );

   erps_gen #(
      .ENTROPY_SPACE (ENTROPY_SPACE)
   ) u_gen (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_advance && s1_send_ff && use_fresh),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .status    (gen_status)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ecn_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ecn_ff  <= last_ecn_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ack_ff     <= req.ack_event;
         s1_ecn_ff     <= req.ecn_total;
         s1_entropy_ff <= req.ack_entropy;
         s1_send_ff    <= req.send_request;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_entropy_valid_ff <= s1_send_ff;
         rsp_next_entropy_ff  <= s1_send_ff ? chosen : '0;
         rsp_recycled_ff      <= s1_send_ff && !use_fresh;
         rsp_status_ff        <= !(s1_ack_ff || s1_send_ff);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.entropy_valid = rsp_entropy_valid_ff;
   assign rsp.next_entropy  = rsp_next_entropy_ff;
   assign rsp.recycled      = rsp_recycled_ff;
   assign rsp.status        = rsp_status_ff;

endmodule

// ----- hw/rtl/erps_checker.sv -----
module erps_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  entropy_valid,
   input erps_pkg::entropy_type next_entropy,
   input logic                  recycled,
   input logic                  status
);
   import erps_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_entropy)
         && $stable(entropy_valid) && $stable(recycled) && $stable(status))
      else $error("result beat changed while stalled");

   // A fresh result comes from a beat accepted into the input register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without an accepted request");

   // An error beat carries no entropy
   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> !entropy_valid && !recycled && (next_entropy == '0))
      else $error("error beat carries entropy");

   // Recycled or nonzero entropy only with a served send
   a_no_send_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !entropy_valid |-> !recycled && (next_entropy == '0))
      else $error("entropy fields set without a send");

endmodule

bind entropy_recycling_path_selector erps_checker u_erps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .entropy_valid (rsp.entropy_valid),
   .next_entropy  (rsp.next_entropy),
   .recycled      (rsp.recycled),
   .status        (rsp.status)
);
